/* hw/rtl/kdp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kdp_pkg
// Shared types and fixed field widths of the 0/1 knapsack table engine.
// ----------------------------------------------------------------------------
package kdp_pkg;

  localparam int VALUE_W  = 16;
  localparam int WEIGHT_W = 10;
  localparam int CAP_W    = 10;
  localparam int BEST_W   = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } kdp_state_t;

  // Per-slot control that travels with one table access.
  typedef struct packed {
    logic valid;   // slot carries a write
    logic clear;   // write zero (power-up clearing pass)
    logic take;    // item fits this capacity
    logic last;    // final item of the run: write zero after capture
    logic hit;     // slot is the configured capacity
    logic first;   // first slot of a sweep
  } kdp_slot_t;

endpackage : kdp_pkg
`default_nettype wire

/* hw/rtl/zero_one_knapsack_dp_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// zero_one_knapsack_dp_top
// 0/1 knapsack solver: best value per capacity kept in one table memory.
// ----------------------------------------------------------------------------
// Sequencing: an accepted item starts one read-modify-write walk over entries
//   CAPACITY_SLOTS-1 down to 1 and then a drain state; done rises after the
//   drain, only for a last item. A new item is taken only once the walk drains.
// Reset: busy stays high while a clearing pass zeroes every table entry;
//   bag_capacity resets to zero.
// The receiver cannot stall: done and best_value are valid for one cycle.
// ----------------------------------------------------------------------------
module zero_one_knapsack_dp_top #(
  parameter int CAPACITY_SLOTS = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // item transaction, taken when start is high and busy is low
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [kdp_pkg::VALUE_W-1:0]  item_value,
  input  wire logic [kdp_pkg::WEIGHT_W-1:0] item_weight,
  input  wire logic                         last_item,
  // configuration: capacity limit of the run
  input  wire logic                         cfg_wr_en,
  input  wire logic [kdp_pkg::CAP_W-1:0]    cfg_wr_data,
  // result transaction, one cycle strobe
  output logic                              done,
  output logic [kdp_pkg::BEST_W-1:0]        best_value
);
  import kdp_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY_SLOTS);

  logic [CAP_W-1:0]  bag_capacity;
  kdp_slot_t         issue;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic [BEST_W-1:0] rd_data_a, rd_data_b;
  logic [VALUE_W-1:0] value_q;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BEST_W-1:0] wr_data;

  // Capacity register: the user must write it only between runs; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      bag_capacity <= '0;
    end else if (cfg_wr_en) begin
      bag_capacity <= cfg_wr_data;
    end
  end

  // Sequencer: walks capacity from the top entry down to entry one, one slot
  // per cycle. Reads of entry c and entry c - weight issue together; entry c
  // is written back in the next cycle, so a read never meets a pending write.
  kdp_seq #(
    .SLOTS  (CAPACITY_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item_value   (item_value),
    .item_weight  (item_weight),
    .last_item    (last_item),
    .bag_capacity (bag_capacity),
    .issue        (issue),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .value_q      (value_q),
    .done         (done)
  );

  // Table memory: one write, two reads per cycle, registered read data.
  kdp_table #(
    .SLOTS  (CAPACITY_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk       (clk),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Update stage: on the final item each entry is written back as zero right
  // after its new value is formed, which clears the table for the next run
  // without a separate pass; the configured entry is captured on the way.
  kdp_merge #(
    .SLOTS  (CAPACITY_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .slot_addr  (rd_addr_a),
    .rd_data_a  (rd_data_a),
    .rd_data_b  (rd_data_b),
    .value_q    (value_q),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .best_value (best_value)
  );

  // A result appears only once the sweep has fully drained.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without a preceding sweep");

  // An accepted item must start a sweep.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not start a sweep");

  // The lower read of a sweep never targets the entry being written back.
  assert property (@(posedge clk) disable iff (rst)
                   (issue.take && wr_en) |-> (rd_addr_b != wr_addr))
    else $error("read of an entry with a pending write");

endmodule : zero_one_knapsack_dp_top
`default_nettype wire

/* hw/rtl/kdp_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kdp_table
// Best-value table: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module kdp_table #(
  parameter int SLOTS  = 1024,
  parameter int ADDR_W = $clog2(SLOTS)
) (
  input  wire logic                      clk,
  input  wire logic [ADDR_W-1:0]         rd_addr_a,
  input  wire logic [ADDR_W-1:0]         rd_addr_b,
  output logic [kdp_pkg::BEST_W-1:0]     rd_data_a,
  output logic [kdp_pkg::BEST_W-1:0]     rd_data_b,
  input  wire logic                      wr_en,
  input  wire logic [ADDR_W-1:0]         wr_addr,
  input  wire logic [kdp_pkg::BEST_W-1:0] wr_data
);
  import kdp_pkg::*;

  logic [BEST_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule : kdp_table
`default_nettype wire

/* hw/rtl/kdp_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kdp_seq
// Sweep sequencer: clearing pass, capacity walk from top to one, drain.
// ----------------------------------------------------------------------------
module kdp_seq #(
  parameter int SLOTS  = 1024,
  parameter int ADDR_W = $clog2(SLOTS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [kdp_pkg::VALUE_W-1:0]  item_value,
  input  wire logic [kdp_pkg::WEIGHT_W-1:0] item_weight,
  input  wire logic                        last_item,
  input  wire logic [kdp_pkg::CAP_W-1:0]    bag_capacity,
  output kdp_pkg::kdp_slot_t               issue,
  output logic [ADDR_W-1:0]                rd_addr_a,
  output logic [ADDR_W-1:0]                rd_addr_b,
  output logic [kdp_pkg::VALUE_W-1:0]       value_q,
  output logic                             done
);
  import kdp_pkg::*;

  localparam int CW = (ADDR_W > CAP_W) ? ADDR_W : CAP_W;
  localparam logic [ADDR_W-1:0] SLOT_TOP = ADDR_W'(SLOTS - 1);
  localparam logic [CW-1:0]     SLOT_TOP_W = CW'(SLOTS - 1);

  kdp_state_t        state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic              done_next;
  logic [WEIGHT_W-1:0] weight_q;
  logic              last_q;
  logic [ADDR_W-1:0] cap_q;

  logic [CW-1:0] cnt_w, weight_w, diff_w, cap_w;
  logic          fits;
  logic          accept;

  assign accept   = start && (state == ST_IDLE);
  assign busy     = (state != ST_IDLE);
  assign cnt_w    = CW'(cnt);
  assign weight_w = CW'(weight_q);
  assign fits     = (weight_w <= cnt_w);
  assign diff_w   = cnt_w - weight_w;
  assign cap_w    = CW'(bag_capacity);
  assign rd_addr_a = cnt;
  assign rd_addr_b = fits ? diff_w[ADDR_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= SLOT_TOP;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  // Hold the item for the whole sweep.
  always_ff @(posedge clk) begin
    if (accept) begin
      value_q  <= item_value;
      weight_q <= item_weight;
      last_q   <= last_item;
      cap_q    <= (cap_w > SLOT_TOP_W) ? SLOT_TOP : cap_w[ADDR_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    done_next  = 1'b0;
    issue      = '0;
    case (state)
      ST_CLEAR: begin
        issue.valid = 1'b1;
        issue.clear = 1'b1;
        if (cnt == '0) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt - ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SWEEP;
          cnt_next   = SLOT_TOP;
        end
      end
      ST_SWEEP: begin
        issue.valid = 1'b1;
        issue.take  = fits;
        issue.last  = last_q;
        issue.hit   = (cnt == cap_q);
        issue.first = (cnt == SLOT_TOP);
        if (cnt == ADDR_W'(1)) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt - ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
        done_next  = last_q;
      end
      default: begin
        state_next = ST_CLEAR;
        cnt_next   = SLOT_TOP;
      end
    endcase
  end

endmodule : kdp_seq
`default_nettype wire

/* hw/rtl/kdp_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kdp_merge
// Update stage: saturating candidate, max against the old entry, write back.
// ----------------------------------------------------------------------------
module kdp_merge #(
  parameter int SLOTS  = 1024,
  parameter int ADDR_W = $clog2(SLOTS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire kdp_pkg::kdp_slot_t           issue,
  input  wire logic [ADDR_W-1:0]            slot_addr,
  input  wire logic [kdp_pkg::BEST_W-1:0]   rd_data_a,
  input  wire logic [kdp_pkg::BEST_W-1:0]   rd_data_b,
  input  wire logic [kdp_pkg::VALUE_W-1:0]  value_q,
  output logic                              wr_en,
  output logic [ADDR_W-1:0]                 wr_addr,
  output logic [kdp_pkg::BEST_W-1:0]        wr_data,
  output logic [kdp_pkg::BEST_W-1:0]        best_value
);
  import kdp_pkg::*;

  kdp_slot_t       ctl_q;
  logic [BEST_W:0] sum;
  logic [BEST_W-1:0] cand, updated;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= issue;
    end
  end

  // Align the address with the registered read data.
  always_ff @(posedge clk) begin
    wr_addr <= slot_addr;
  end

  assign sum     = {1'b0, rd_data_b} + (BEST_W + 1)'(value_q);
  assign cand    = sum[BEST_W] ? '1 : sum[BEST_W-1:0];
  assign updated = (ctl_q.take && (cand > rd_data_a)) ? cand : rd_data_a;

  assign wr_en   = ctl_q.valid;
  assign wr_data = (ctl_q.clear || ctl_q.last) ? '0 : updated;

  // Capture the configured entry; a capacity of zero never hits and reads zero.
  always_ff @(posedge clk) begin
    if (ctl_q.valid && !ctl_q.clear && ctl_q.hit) begin
      best_value <= updated;
    end else if (ctl_q.valid && ctl_q.first) begin
      best_value <= '0;
    end
  end

endmodule : kdp_merge
`default_nettype wire

/* tb/sv/tb_zero_one_knapsack_dp_top.sv */
// ----------------------------------------------------------------------------
// tb_zero_one_knapsack_dp_top
// Self-checking bench for the 0/1 knapsack table engine. A scoreboard keeps
// its own best-value-per-capacity table, updates it for every item the block
// accepts and predicts the result of each finished set. Results are matched
// in order against the block's done strobe. Stimulus runs a directed part
// over the corner cases, then random sets under several capacity limits and
// sender idling patterns.
// ----------------------------------------------------------------------------
module tb_zero_one_knapsack_dp_top;
  import kdp_pkg::*;

  localparam int SLOTS = 1024;
  // Slowest legal item: sweep plus the longest sender hold-off; 3x margin.
  localparam int LIMIT = 600 * (2 * SLOTS + 80) * 3;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow table, capacity register and pending results.
  // --------------------------------------------------------------------------
  class knapsack_scoreboard;
    bit [BEST_W-1:0] best_tbl [SLOTS];
    bit [CAP_W-1:0]  capacity;
    bit [BEST_W-1:0] pending_best [$];
    int              fails;

    // Fold one accepted item into the table; queue the answer on a last item.
    function void note_item(input bit [VALUE_W-1:0] v, input bit [WEIGHT_W-1:0] w,
                            input bit fin);
      bit [BEST_W:0] sum;
      int unsigned   c;
      int unsigned   cap;
      for (c = SLOTS - 1; c >= 1; c--) begin
        if (w <= c) begin
          sum = {1'b0, best_tbl[c - w]} + v;
          if (sum[BEST_W]) sum = {1'b0, {BEST_W{1'b1}}};
          if (sum[BEST_W-1:0] > best_tbl[c]) best_tbl[c] = sum[BEST_W-1:0];
        end
      end
      best_tbl[0] = '0;
      if (fin) begin
        cap = (capacity > SLOTS - 1) ? SLOTS - 1 : capacity;
        pending_best.push_back(best_tbl[cap]);
        foreach (best_tbl[i]) best_tbl[i] = '0;
      end
    endfunction

    function void check_result(input bit [BEST_W-1:0] got);
      bit [BEST_W-1:0] want;
      if (pending_best.size() == 0) begin
        $error("best_value: expected none, actual %0d", got);
        fails++;
      end else begin
        want = pending_best.pop_front();
        if (got !== want) begin
          $error("best_value: expected %0d, actual %0d", want, got);
          fails++;
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [VALUE_W-1:0]  item_value = '0;
  logic [WEIGHT_W-1:0] item_weight = '0;
  logic                last_item = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]    cfg_wr_data = '0;
  logic                done;
  logic [BEST_W-1:0]   best_value;

  knapsack_scoreboard sb = new();
  int cycles = 0;

  zero_one_knapsack_dp_top #(.CAPACITY_SLOTS(SLOTS)) DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item_value  (item_value),
    .item_weight (item_weight),
    .last_item   (last_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .done        (done),
    .best_value  (best_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Monitor: sample every handshake at the edge that completes it.
  // Check results before noting a new item so an item taken on the same
  // edge as a done strobe cannot disturb the older expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(best_value);
      if (cfg_wr_en) sb.capacity = cfg_wr_data;
      if (start && !busy) sb.note_item(item_value, item_weight, last_item);
    end
  end

  // Write the capacity register for one cycle.
  task automatic write_capacity(input bit [CAP_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Offer one item transaction and hold it until the block takes it.
  // In idling phases some items first hold off for up to a full sweep so
  // that start rises at every point of the block's walk, then idle for a
  // random run of cycles at the given percentage.
  task automatic send_item(input bit [VALUE_W-1:0] v, input bit [WEIGHT_W-1:0] w,
                           input bit fin, input int idle_pct);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(3) == 0) gap = $urandom_range(SLOTS + 8);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    gap = 0;
    while (gap < 64 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      gap++;
    end
    start       <= 1'b1;
    item_value  <= v;
    item_weight <= w;
    last_item   <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start, wait for every expected result, then let the sweep settle
  // before the next register write.
  task automatic drain_phase();
    start <= 1'b0;
    while (sb.pending_best.size() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  // Pick a weight that mostly lands inside the bag so choices matter.
  function automatic bit [WEIGHT_W-1:0] pick_weight(input int cap);
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return WEIGHT_W'($urandom_range(0, cap / 3 + 1));
    if (sel < 7) return WEIGHT_W'($urandom_range(0, (cap == 0) ? 3 : cap));
    return WEIGHT_W'($urandom_range(0, (1 << WEIGHT_W) - 1));
  endfunction

  function automatic bit [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(19);
    if (sel < 2) return '1;
    if (sel == 2) return '0;
    return VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
  endfunction

  int idle_tbl [4] = '{0, 83, 0, 18};

  initial begin
    int cap;
    int set_left;
    bit fin;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: a zero capacity keeps the answer at zero, even when an
    // item of weight zero is added everywhere else.
    write_capacity('0);
    send_item('1, '0, 1'b0, 0);
    send_item(16'd1, 10'd1, 1'b1, 0);
    drain_phase();

    // Full capacity: weight zero, weight at the top, and two items that
    // exactly fill the bag together.
    write_capacity('1);
    send_item('1, '0, 1'b0, 0);
    send_item('1, '1, 1'b0, 0);
    send_item(16'd100, 10'd512, 1'b0, 0);
    send_item(16'd200, 10'd511, 1'b0, 0);
    send_item(16'd7, '1, 1'b1, 0);
    // A lone last item right after a clear.
    send_item(16'd0, 10'd0, 1'b1, 0);
    drain_phase();

    // Small bag: a true trade-off, closed by an item too heavy to fit.
    write_capacity(10'd5);
    send_item(16'd10, 10'd3, 1'b0, 0);
    send_item(16'd10, 10'd3, 1'b0, 0);
    send_item(16'd15, 10'd5, 1'b0, 0);
    send_item(16'd3, 10'd2, 1'b0, 0);
    send_item(16'd40, 10'd1000, 1'b1, 0);
    drain_phase();

    // Capacity one: weight one fits, weight zero stacks on top.
    write_capacity(10'd1);
    send_item('1, 10'd1, 1'b0, 0);
    send_item(16'd2, 10'd2, 1'b0, 0);
    send_item(16'd1, 10'd0, 1'b1, 0);
    drain_phase();

    // Random phases: new capacity each phase, idling pattern cycles.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 4:    cap = (1 << CAP_W) - 1;
        1:       cap = 0;
        2:       cap = $urandom_range(1, 15);
        6:       cap = 1;
        default: cap = $urandom_range(0, (1 << CAP_W) - 1);
      endcase
      write_capacity(cap[CAP_W-1:0]);
      set_left = 0;
      for (int k = 0; k < 70; k++) begin
        if (set_left == 0) set_left = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 12);
        set_left--;
        // Close sets where planned, break some early, close the phase.
        fin = (set_left == 0) || (k == 69) || ($urandom_range(19) == 0);
        if (fin) set_left = 0;
        send_item(pick_value(), pick_weight(cap), fin, idle_tbl[ph % 4]);
      end
      drain_phase();
    end

    if (sb.pending_best.size() != 0) begin
      $error("best_value: %0d expected results never arrived", sb.pending_best.size());
      sb.fails++;
    end
    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
